FILE: rtl/first_fit_heap_allocator_top_macros.svh
// assertion macros for the first-fit heap allocator checker
// no dependencies; included by the checker file only
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffha check failed");

// next-cycle implication, disabled during reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffha check failed");

`endif

FILE: rtl/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// no dependencies; imported by every module of the block
package ffha_pkg;

	// fixed widths of the request, result and header size fields
	localparam int SIZE_W = 11;
	// working width for header positions and block ends
	localparam int CALC_W = 13;

	// request operation codes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// one header entry: payload size and allocated flag
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              used;
	} entry_t;

	// finished result handed from the walker to the output register
	typedef struct packed {
		logic [SIZE_W-1:0] offset;
		status_t           status;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_EVAL,
		S_NXT,
		S_SPLIT,
		S_FREE,
		S_RESP
	} walk_state_t;

endpackage

FILE: rtl/ffha_mem.sv
// header store: one write port, one read port with registered read data
// depends on ffha_pkg for the entry type
module ffha_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  ffha_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ffha_pkg::entry_t rd_data
);
	import ffha_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/ffha_walker.sv
// header walk sequencer: reads, checks and rewrites headers for one request
// depends on ffha_pkg; drives the ports of ffha_mem
module ffha_walker #(
	parameter int ARENA_BYTES  = 1024,
	parameter int HEADER_BYTES = 8,
	parameter int AW           = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ffha_pkg::SIZE_W-1:0]    cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [ffha_pkg::SIZE_W-1:0]    request_size,
	input  logic [ffha_pkg::SIZE_W-1:0]    release_address,
	output logic                           res_valid,
	output ffha_pkg::result_t              res,
	input  logic                           res_ack,
	output logic                           mem_wr_en,
	output logic [AW-1:0]                  mem_wr_addr,
	output ffha_pkg::entry_t               mem_wr_data,
	output logic                           mem_rd_en,
	output logic [AW-1:0]                  mem_rd_addr,
	input  ffha_pkg::entry_t               mem_rd_data
);
	import ffha_pkg::*;

	localparam int CW = (AW + 1 > CALC_W) ? AW + 1 : CALC_W;
	localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
	localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);

	walk_state_t       state_q, state_d;
	logic [SIZE_W-1:0] total_q;
	logic              op_q;
	logic [SIZE_W-1:0] req_q;
	logic [SIZE_W-1:0] addr_q;
	logic [CW-1:0]     pos_q;
	logic [AW-1:0]     prev_pos_q;
	logic [SIZE_W-1:0] prev_sz_q;
	logic              prev_used_q;
	logic              have_prev_q;
	logic [SIZE_W-1:0] cur_sz_q;
	logic [SIZE_W-1:0] res_offset_q;
	status_t           res_status_q;

	logic [SIZE_W-1:0] cfg_total;
	logic [CW-1:0]     total_w;
	logic [CW-1:0]     req_w;
	logic [CW-1:0]     rd_sz_w;
	logic [CW-1:0]     end_pos;
	logic [CW-1:0]     tail_pos;
	logic              pos_in_range;
	logic              end_in_range;
	logic              fits;
	logic              split;
	logic              match;
	logic              merge_prev;

	// arena size saturated to the store depth
	assign cfg_total = (CW'(cfg_wr_data) > ARENA_C) ? SIZE_W'(ARENA_C) : cfg_wr_data;

	// walk conditions on the current header
	assign total_w      = CW'(total_q);
	assign req_w        = CW'(req_q);
	assign rd_sz_w      = CW'(mem_rd_data.size);
	assign end_pos      = pos_q + HDR_C + rd_sz_w;
	assign tail_pos     = pos_q + HDR_C + req_w;
	assign pos_in_range = (pos_q + HDR_C <= total_w) && (pos_q < ARENA_C);
	assign end_in_range = (end_pos + HDR_C <= total_w) && (end_pos < ARENA_C);
	assign fits         = !mem_rd_data.used && (mem_rd_data.size >= req_q);
	assign split        = (rd_sz_w > req_w + HDR_C) && (tail_pos < ARENA_C);
	assign match        = (pos_q + HDR_C == CW'(addr_q));
	assign merge_prev   = have_prev_q && !prev_used_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHK;
			end
			S_CHK: begin
				state_d = pos_in_range ? S_EVAL : S_RESP;
			end
			S_EVAL: begin
				if (op_q == OP_ALLOC) begin
					if (fits) state_d = split ? S_SPLIT : S_RESP;
					else      state_d = S_CHK;
				end else begin
					if (!match)                 state_d = S_CHK;
					else if (!mem_rd_data.used) state_d = S_RESP;
					else if (end_in_range)      state_d = S_NXT;
					else                        state_d = S_FREE;
				end
			end
			S_NXT:   state_d = S_FREE;
			S_SPLIT: state_d = S_RESP;
			S_FREE:  state_d = S_RESP;
			S_RESP: begin
				if (res_ack) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store accesses
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = pos_q[AW-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = pos_q[AW-1:0];
		mem_wr_data = '{size: cur_sz_q, used: 1'b0};
		if (cfg_wr_en) begin
			// new arena: one free block at offset zero
			mem_wr_en   = (CW'(cfg_total) >= HDR_C);
			mem_wr_addr = '0;
			mem_wr_data = '{size: SIZE_W'(CW'(cfg_total) - HDR_C), used: 1'b0};
		end else begin
			unique case (state_q)
				S_CHK: begin
					mem_rd_en = pos_in_range;
				end
				S_EVAL: begin
					if (op_q == OP_ALLOC) begin
						if (fits && split) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = tail_pos[AW-1:0];
							mem_wr_data = '{size: SIZE_W'(rd_sz_w - req_w - HDR_C),
								used: 1'b0};
						end else if (fits) begin
							mem_wr_en   = 1'b1;
							mem_wr_data = '{size: mem_rd_data.size, used: 1'b1};
						end
					end else if (match && mem_rd_data.used && end_in_range) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = end_pos[AW-1:0];
					end
				end
				S_SPLIT: begin
					mem_wr_en   = 1'b1;
					mem_wr_data = '{size: req_q, used: 1'b1};
				end
				S_FREE: begin
					mem_wr_en = 1'b1;
					if (merge_prev) begin
						mem_wr_addr = prev_pos_q;
						mem_wr_data = '{size: SIZE_W'(CW'(prev_sz_q) + HDR_C + CW'(cur_sz_q)),
							used: 1'b0};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) total_q <= cfg_total;
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q        <= operation;
					req_q       <= request_size;
					addr_q      <= release_address;
					pos_q       <= '0;
					have_prev_q <= 1'b0;
				end
			end
			S_CHK: begin
				if (!pos_in_range) begin
					res_offset_q <= '0;
					res_status_q <= (op_q == OP_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
				end
			end
			S_EVAL: begin
				if (op_q == OP_ALLOC) begin
					if (fits) begin
						res_offset_q <= SIZE_W'(pos_q + HDR_C);
						res_status_q <= ST_OK;
					end else begin
						pos_q <= end_pos;
					end
				end else if (match) begin
					res_offset_q <= '0;
					res_status_q <= mem_rd_data.used ? ST_OK : ST_NOT_FOUND;
					cur_sz_q     <= mem_rd_data.size;
				end else begin
					prev_pos_q  <= pos_q[AW-1:0];
					prev_sz_q   <= mem_rd_data.size;
					prev_used_q <= mem_rd_data.used;
					have_prev_q <= 1'b1;
					pos_q       <= end_pos;
				end
			end
			S_NXT: begin
				// absorb a free block that follows
				if (!mem_rd_data.used) begin
					cur_sz_q <= SIZE_W'(CW'(cur_sz_q) + HDR_C + rd_sz_w);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_RESP);
	assign res.offset = res_offset_q;
	assign res.status = res_status_q;

endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing over a header store.
// Channels: request in (in_valid/in_ready with operation, request_size,
// release_address), result out (out_valid/out_ready with payload_offset,
// status), and a one-register configuration port (cfg_wr_en/cfg_wr_data)
// that sets the arena size and turns the arena into one free block.
// Each request walks the block headers from offset zero in address order;
// every header is handled as a store read, then a check, an order set by
// the single read port of the header store. A release may also read the
// header that follows to merge it. A walk visits at most arena_size /
// HEADER_BYTES headers. One request is worked on at a time.
// Results land in an output register; the next request is taken while a
// result waits there, and a finished walk holds until that register frees.
// A receiver stall holds out_valid and the result fields steady.
// Reset clears the arena size to zero (every allocation then fails) and the
// control state; the header store needs no clearing pass, as only headers
// written since the last arena size write are read.
// Depends on ffha_pkg, ffha_walker and ffha_mem.
module first_fit_heap_allocator_top #(
	parameter int ARENA_BYTES  = 1024,
	parameter int HEADER_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ffha_pkg::SIZE_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [ffha_pkg::SIZE_W-1:0] request_size,
	input  logic [ffha_pkg::SIZE_W-1:0] release_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ffha_pkg::SIZE_W-1:0] payload_offset,
	output logic [1:0]                  status
);
	import ffha_pkg::*;

	localparam int AW = $clog2(ARENA_BYTES);

	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	entry_t            mem_wr_data;
	logic              mem_rd_en;
	logic [AW-1:0]     mem_rd_addr;
	entry_t            mem_rd_data;
	logic              res_valid;
	logic              res_ack;
	result_t           res;
	logic              out_valid_q;
	logic [SIZE_W-1:0] payload_offset_q;
	status_t           status_q;

	ffha_walker #(
		.ARENA_BYTES  (ARENA_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.AW           (AW)
	) u_walker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.request_size    (request_size),
		.release_address (release_address),
		.res_valid       (res_valid),
		.res             (res),
		.res_ack         (res_ack),
		.mem_wr_en       (mem_wr_en),
		.mem_wr_addr     (mem_wr_addr),
		.mem_wr_data     (mem_wr_data),
		.mem_rd_en       (mem_rd_en),
		.mem_rd_addr     (mem_rd_addr),
		.mem_rd_data     (mem_rd_data)
	);

	ffha_mem #(
		.DEPTH (ARENA_BYTES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output register takes a result when empty or being drained
	assign res_ack = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			payload_offset_q <= res.offset;
			status_q         <= res.status;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_offset = payload_offset_q;
	assign status         = status_q;

endmodule

FILE: rtl/ffha_checker.sv
// port-level checks for the first-fit heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator_top_macros.svh
`include "first_fit_heap_allocator_top_macros.svh"

module ffha_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ffha_pkg::SIZE_W-1:0] payload_offset,
	input logic [1:0]                  status
);
	import ffha_pkg::*;

	// a stalled result stays put
	`FFHA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(payload_offset) && $stable(status))

	// one request at a time: taking a request closes the input
	`FFHA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a failed request never carries an offset
	`FFHA_ASSERT_NOW(a_fail_zero_offset, clk, arst_n, out_valid && (status != ST_OK), payload_offset == '0)

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.payload_offset (payload_offset),
	.status         (status)
);
